// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the matrix-to-quaternion block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define M2Q_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define M2Q_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define M2Q_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define M2Q_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== hw/rtl/m2q_pkg.sv =====
// Types, constants and width helpers for the matrix-to-quaternion block.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
package m2q_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int ELEM_W        = 16;
    // Sums and differences of two elements, negated, need 18 signed bits.
    localparam int NUM_W         = 18;
    localparam int LANES         = 3;

    typedef enum logic [1:0] {
        CASE_TRACE = 2'd0,
        CASE_X     = 2'd1,
        CASE_Y     = 2'd2,
        CASE_Z     = 2'd3
    } t_case;

    typedef struct packed {
        logic signed [ELEM_W-1:0] elem_00;
        logic signed [ELEM_W-1:0] elem_01;
        logic signed [ELEM_W-1:0] elem_02;
        logic signed [ELEM_W-1:0] elem_10;
        logic signed [ELEM_W-1:0] elem_11;
        logic signed [ELEM_W-1:0] elem_12;
        logic signed [ELEM_W-1:0] elem_20;
        logic signed [ELEM_W-1:0] elem_21;
        logic signed [ELEM_W-1:0] elem_22;
    } t_m2q_in;

    typedef struct packed {
        logic signed [ELEM_W-1:0] quat_w;
        logic signed [ELEM_W-1:0] quat_x;
        logic signed [ELEM_W-1:0] quat_y;
        logic signed [ELEM_W-1:0] quat_z;
        t_case                    case_taken;
        logic                     degenerate;
    } t_m2q_out;

    // Magnitude bits of a positive root argument.
    function automatic int mag_bits(input int f);
        return ((f > 17) ? f : 17) + 1;
    endfunction

    // Bits of the square root of the scaled root argument.
    function automatic int sq_w(input int f);
        return (mag_bits(f) + f + 1) >> 1;
    endfunction

endpackage

// ===== hw/rtl/m2q_front.sv =====
// Front stage: trace, case selection, root argument and lane numerators.
// Depends on m2q_pkg.
`timescale 1ns / 1ps
module m2q_front #(
    parameter int FRAC_BITS = m2q_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  m2q_pkg::t_m2q_in                     i_item,
    output logic                                 o_valid,
    output logic [2*m2q_pkg::sq_w(FRAC_BITS)-1:0] o_rad,
    output m2q_pkg::t_case                       o_sel,
    output logic signed [m2q_pkg::NUM_W-1:0]     o_num [m2q_pkg::LANES]
);
    localparam int MAG_W = m2q_pkg::mag_bits(FRAC_BITS);
    localparam int ARG_W = MAG_W + 1;
    localparam int RAD_W = 2 * m2q_pkg::sq_w(FRAC_BITS);
    localparam int NW    = m2q_pkg::NUM_W;

    logic signed [NW-1:0]    e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [NW-1:0]    trace;
    logic signed [ARG_W-1:0] one_a, a00, a11, a22, arg;
    m2q_pkg::t_case          n_sel;
    logic [RAD_W-1:0]        n_rad;
    logic signed [NW-1:0]    n_num [m2q_pkg::LANES];

    logic                    r_valid;
    logic [RAD_W-1:0]        r_rad;
    m2q_pkg::t_case          r_sel;
    logic signed [NW-1:0]    r_num [m2q_pkg::LANES];

    always_comb begin
        e00 = NW'(i_item.elem_00);
        e01 = NW'(i_item.elem_01);
        e02 = NW'(i_item.elem_02);
        e10 = NW'(i_item.elem_10);
        e11 = NW'(i_item.elem_11);
        e12 = NW'(i_item.elem_12);
        e20 = NW'(i_item.elem_20);
        e21 = NW'(i_item.elem_21);
        e22 = NW'(i_item.elem_22);
        trace = e00 + e11 + e22;
        one_a = ARG_W'(1) << FRAC_BITS;
        a00 = ARG_W'(e00);
        a11 = ARG_W'(e11);
        a22 = ARG_W'(e22);
        // Signs of each case are folded into the numerators.
        if (trace > 0) begin
            n_sel = m2q_pkg::CASE_TRACE;
            arg = one_a + a00 + a11 + a22;
            n_num[0] = e12 - e21;
            n_num[1] = e02 - e20;
            n_num[2] = e10 - e01;
        end else if (e00 > e11 && e00 > e22) begin
            n_sel = m2q_pkg::CASE_X;
            arg = one_a + a00 - a11 - a22;
            n_num[0] = e21 - e12;
            n_num[1] = e01 + e10;
            n_num[2] = e02 + e20;
        end else if (e11 > e22) begin
            n_sel = m2q_pkg::CASE_Y;
            arg = one_a + a11 - a00 - a22;
            n_num[0] = e20 - e02;
            n_num[1] = e01 + e10;
            n_num[2] = -(e12 + e21);
        end else begin
            n_sel = m2q_pkg::CASE_Z;
            arg = one_a + a22 - a00 - a11;
            n_num[0] = e01 - e10;
            n_num[1] = e02 + e20;
            n_num[2] = -(e12 + e21);
        end
        // A root argument that is not positive gives a zero radicand.
        if (arg > 0) begin
            n_rad = RAD_W'({arg[ARG_W-2:0], {FRAC_BITS{1'b0}}});
        end else begin
            n_rad = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad <= n_rad;
            r_sel <= n_sel;
            r_num <= n_num;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_sel   = r_sel;
    assign o_num   = r_num;
endmodule

// ===== hw/rtl/m2q_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on m2q_pkg.
`timescale 1ns / 1ps
module m2q_sqrt #(
    parameter int FRAC_BITS = m2q_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W    = 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [2*m2q_pkg::sq_w(FRAC_BITS)-1:0] i_rad,
    input  logic [SIDE_W-1:0]                     i_side,
    output logic                                  o_valid,
    output logic [m2q_pkg::sq_w(FRAC_BITS)-1:0]   o_root,
    output logic [SIDE_W-1:0]                     o_side
);
    localparam int SQ_W  = m2q_pkg::sq_w(FRAC_BITS);
    localparam int RAD_W = 2 * SQ_W;
    localparam int REM_W = SQ_W + 3;

    logic              r_v    [0:SQ_W];
    logic [REM_W-1:0]  r_rem  [0:SQ_W];
    logic [SQ_W-1:0]   r_root [0:SQ_W];
    logic [RAD_W-1:0]  r_rad  [0:SQ_W];
    logic [SIDE_W-1:0] r_side [0:SQ_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_rad[0]  <= i_rad;
            r_side[0] <= i_side;
        end
    end

    for (genvar s = 0; s < SQ_W; s++) begin : g_stage
        logic [REM_W-1:0] n_sh;
        logic [REM_W-1:0] n_trial;
        logic             n_ge;

        assign n_sh    = {r_rem[s][REM_W-3:0], r_rad[s][RAD_W-1 -: 2]};
        assign n_trial = {1'b0, r_root[s], 2'b01};
        assign n_ge    = (n_sh >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1]  <= n_ge ? (n_sh - n_trial) : n_sh;
                r_root[s+1] <= {r_root[s][SQ_W-2:0], n_ge};
                r_rad[s+1]  <= {r_rad[s][RAD_W-3:0], 2'b00};
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_v[SQ_W];
    assign o_root  = r_root[SQ_W];
    assign o_side  = r_side[SQ_W];
endmodule

// ===== hw/rtl/m2q_div.sv =====
// Three-lane pipelined restoring divider: round(|num| * 2^F / (2r)), one
// quotient bit per stage, with sign and sideband carried along. Uses m2q_pkg.
`timescale 1ns / 1ps
module m2q_div #(
    parameter int FRAC_BITS = m2q_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W    = 1
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  logic signed [m2q_pkg::NUM_W-1:0]        i_num [m2q_pkg::LANES],
    input  logic [m2q_pkg::sq_w(FRAC_BITS)-1:0]     i_root,
    input  logic [SIDE_W-1:0]                       i_side,
    output logic                                    o_valid,
    output logic [m2q_pkg::NUM_W+FRAC_BITS-1:0]     o_quot [m2q_pkg::LANES],
    output logic [m2q_pkg::LANES-1:0]               o_neg,
    output logic [m2q_pkg::sq_w(FRAC_BITS)-1:0]     o_root,
    output logic [SIDE_W-1:0]                       o_side
);
    localparam int SQ_W  = m2q_pkg::sq_w(FRAC_BITS);
    localparam int NW    = m2q_pkg::NUM_W;
    localparam int DVD_W = NW + FRAC_BITS;
    localparam int REM_W = SQ_W + 2;
    localparam int NL    = m2q_pkg::LANES;

    logic                     r_v    [0:DVD_W];
    logic [DVD_W-1:0]         r_dvd  [0:DVD_W][NL];
    logic [REM_W-1:0]         r_rem  [0:DVD_W][NL];
    logic [NL-1:0]            r_neg  [0:DVD_W];
    logic [SQ_W-1:0]          r_root [0:DVD_W];
    logic [SIDE_W-1:0]        r_side [0:DVD_W];
    logic [DVD_W-1:0]         n_dvd0 [NL];
    logic [NL-1:0]            n_neg0;

    // Entry: the magnitude is scaled and half the divisor added for rounding.
    always_comb begin
        for (int k = 0; k < NL; k++) begin
            logic signed [NW-1:0] mag;
            mag = i_num[k][NW-1] ? -i_num[k] : i_num[k];
            n_neg0[k] = i_num[k][NW-1];
            n_dvd0[k] = DVD_W'({mag[NW-2:0], {FRAC_BITS{1'b0}}}) + DVD_W'(i_root);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NL; k++) begin
                r_dvd[0][k] <= n_dvd0[k];
                r_rem[0][k] <= '0;
            end
            r_neg[0]  <= n_neg0;
            r_root[0] <= i_root;
            r_side[0] <= i_side;
        end
    end

    for (genvar s = 0; s < DVD_W; s++) begin : g_stage
        logic [REM_W-1:0] n_den;

        assign n_den = REM_W'({r_root[s], 1'b0});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
        end

        for (genvar k = 0; k < NL; k++) begin : g_lane
            logic [REM_W-1:0] n_sh;
            logic             n_ge;

            assign n_sh = {r_rem[s][k][REM_W-2:0], r_dvd[s][k][DVD_W-1]};
            assign n_ge = (n_sh >= n_den);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s+1][k] <= n_ge ? (n_sh - n_den) : n_sh;
                    r_dvd[s+1][k] <= {r_dvd[s][k][DVD_W-2:0], n_ge};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[s+1]  <= r_neg[s];
                r_root[s+1] <= r_root[s];
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_v[DVD_W];
    assign o_quot  = r_dvd[DVD_W];
    assign o_neg   = r_neg[DVD_W];
    assign o_root  = r_root[DVD_W];
    assign o_side  = r_side[DVD_W];
endmodule

// ===== hw/rtl/matrix_to_quaternion.sv =====
// Top level of the rotation-matrix to quaternion converter.
// Depends on m2q_pkg, m2q_front, m2q_sqrt, m2q_div and assert_macros.svh.
//
//   Channel  Direction  Handshake            Payload
//   input    in         i_valid / o_stall    i_item (m2q_pkg::t_m2q_in)
//   output   out        o_valid / i_stall    o_item (m2q_pkg::t_m2q_out)
//
// A new item can be accepted in every cycle unless the output is stalled. The
// pipe is one front stage, a load stage plus one stage per root bit, a load
// stage plus one stage per quotient bit, and the output register; the divider
// chain is the longest part of it.
// Reset (synchronous, active low) clears only the valid bits along the pipe.
// The whole pipe advances whenever the output register is empty or being taken,
// so a stall on the output freezes every stage and nothing is lost or repeated.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module matrix_to_quaternion #(
    parameter int FRAC_BITS = m2q_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  m2q_pkg::t_m2q_in  i_item,
    output logic              o_stall,
    output logic              o_valid,
    output m2q_pkg::t_m2q_out o_item,
    input  logic              i_stall
);
    localparam int SQ_W   = m2q_pkg::sq_w(FRAC_BITS);
    localparam int RAD_W  = 2 * SQ_W;
    localparam int NW     = m2q_pkg::NUM_W;
    localparam int NL     = m2q_pkg::LANES;
    localparam int DVD_W  = NW + FRAC_BITS;
    localparam int EW     = m2q_pkg::ELEM_W;
    localparam int SIDE_A = 2 + NL * NW;

    // Pipeline enable: every stage moves together.
    logic                 pipe_en;

    logic                 fr_valid;
    logic [RAD_W-1:0]     fr_rad;
    m2q_pkg::t_case       fr_sel;
    logic signed [NW-1:0] fr_num [NL];

    logic [SIDE_A-1:0]    sq_side_in;
    logic                 sq_valid;
    logic [SQ_W-1:0]      sq_root;
    logic [SIDE_A-1:0]    sq_side;
    logic signed [NW-1:0] sq_num [NL];

    logic                 dv_valid;
    logic [DVD_W-1:0]     dv_quot [NL];
    logic [NL-1:0]        dv_neg;
    logic [SQ_W-1:0]      dv_root;
    logic [1:0]           dv_side;

    logic [DVD_W-1:0]     half;
    logic signed [EW-1:0] half_neg, half_pos;
    logic signed [EW-1:0] lane_q [NL];
    m2q_pkg::t_case       out_sel;
    m2q_pkg::t_m2q_out    n_out;

    logic                 r_out_valid;
    m2q_pkg::t_m2q_out    r_out;

    // Clamp a magnitude with sign to the signed 16-bit output range.
    function automatic logic signed [EW-1:0] sat_mag(input logic [DVD_W-1:0] mag,
                                                     input logic neg);
        logic signed [EW-1:0] res;
        if (!neg) begin
            res = (mag > DVD_W'(32767)) ? 16'sh7FFF : mag[EW-1:0];
        end else begin
            res = (mag > DVD_W'(32768)) ? 16'sh8000 : -mag[EW-1:0];
        end
        return res;
    endfunction

    assign pipe_en = !r_out_valid || !i_stall;
    assign o_stall = r_out_valid && i_stall;

    m2q_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_valid (fr_valid),
        .o_rad   (fr_rad),
        .o_sel   (fr_sel),
        .o_num   (fr_num)
    );

    assign sq_side_in = {fr_sel, fr_num[0], fr_num[1], fr_num[2]};

    m2q_sqrt #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE_A)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (fr_valid),
        .i_rad   (fr_rad),
        .i_side  (sq_side_in),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign sq_num[0] = sq_side[3*NW-1 -: NW];
    assign sq_num[1] = sq_side[2*NW-1 -: NW];
    assign sq_num[2] = sq_side[NW-1:0];

    m2q_div #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (2)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (sq_valid),
        .i_num   (sq_num),
        .i_root  (sq_root),
        .i_side  (sq_side[SIDE_A-1 -: 2]),
        .o_valid (dv_valid),
        .o_quot  (dv_quot),
        .o_neg   (dv_neg),
        .o_root  (dv_root),
        .o_side  (dv_side)
    );

    // Output stage: halve the root, saturate, and place the components.
    always_comb begin
        half     = DVD_W'((SQ_W+1)'(dv_root) + (SQ_W+1)'(1)) >> 1;
        half_pos = sat_mag(half, 1'b0);
        half_neg = sat_mag(half, 1'b1);
        for (int k = 0; k < NL; k++) begin
            lane_q[k] = sat_mag(dv_quot[k], dv_neg[k]);
        end
        out_sel = m2q_pkg::t_case'(dv_side);
        n_out.case_taken = out_sel;
        n_out.degenerate = (dv_root == '0);
        case (out_sel)
            m2q_pkg::CASE_TRACE: begin
                n_out.quat_w = half_pos;
                n_out.quat_x = lane_q[0];
                n_out.quat_y = lane_q[1];
                n_out.quat_z = lane_q[2];
            end
            m2q_pkg::CASE_X: begin
                n_out.quat_w = lane_q[0];
                n_out.quat_x = half_neg;
                n_out.quat_y = lane_q[1];
                n_out.quat_z = lane_q[2];
            end
            m2q_pkg::CASE_Y: begin
                n_out.quat_w = lane_q[0];
                n_out.quat_x = lane_q[1];
                n_out.quat_y = half_neg;
                n_out.quat_z = lane_q[2];
            end
            default: begin
                n_out.quat_w = lane_q[0];
                n_out.quat_x = lane_q[1];
                n_out.quat_y = lane_q[2];
                n_out.quat_z = half_neg;
            end
        endcase
        // A zero root means the argument was not positive: give the identity.
        if (n_out.degenerate) begin
            n_out.quat_w = sat_mag(DVD_W'(1) << FRAC_BITS, 1'b0);
            n_out.quat_x = '0;
            n_out.quat_y = '0;
            n_out.quat_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // A degenerate result must carry the identity's vector part.
    `M2Q_ASSERT_IMPLY(a_degen_identity, i_clk, i_rst_n, o_valid && o_item.degenerate, o_item.quat_x == 16'sd0 && o_item.quat_y == 16'sd0 && o_item.quat_z == 16'sd0, "degenerate result without zero vector part")
    // In the trace case the scalar part is half a root, never negative.
    `M2Q_ASSERT_IMPLY(a_trace_w_sign, i_clk, i_rst_n, o_valid && !o_item.degenerate && o_item.case_taken == m2q_pkg::CASE_TRACE, !o_item.quat_w[EW-1], "negative scalar part in trace case")
    // In the x case the x component is minus half a root.
    `M2Q_ASSERT_NEVER(a_xcase_x_sign, i_clk, i_rst_n, o_valid && !o_item.degenerate && o_item.case_taken == m2q_pkg::CASE_X && !o_item.quat_x[EW-1] && o_item.quat_x != 16'sd0, "positive x component in x case")
endmodule
